/* sv/ssdp_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse scaled dot product package
// Shared types and constants for controller and datapath.
// ----------------------------------------------------------------------------
package ssdp_pkg;

	localparam logic [1:0] CMD_ROW     = 2'd0;
	localparam logic [1:0] CMD_COL     = 2'd1;
	localparam logic [1:0] CMD_SCALE   = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	// Configuration register byte addresses.
	localparam logic [1:0] REG_SCALE_EN = 2'd0;

	localparam int KEY_W = 10;
	localparam int VAL_W = 32;
	localparam int ACC_W = 64;
	// Scale table depth; the 10-bit key covers all of it.
	localparam int KEY_SPACE = 1024;
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;    // begin a compute walk
		logic step;     // advance the walk one step
		logic finish;   // clear lists after the result is taken
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;     // walk finished, result held
	} ctl_sts_t;

endpackage

/* sv/ssdp_datapath.sv */
// ----------------------------------------------------------------------------
// Sparse scaled dot product datapath
// List and scale memories, merge walk, term multiply and saturating sums.
// ----------------------------------------------------------------------------
module ssdp_datapath #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_en,
	input  logic [1:0]             cmd,
	input  logic [9:0]             key,
	input  logic signed [31:0]     value,
	input  logic                   scale_enable,
	input  ssdp_pkg::ctl_cmd_t     ctl,
	output ssdp_pkg::ctl_sts_t     sts,
	output logic signed [63:0]     dot_result,
	output logic                   saturated,
	output logic                   list_full
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = $clog2(ssdp_pkg::KEY_SPACE);

	// Memories.
	logic [9:0]         rk_mem [MAX_ENTRIES];
	logic signed [31:0] rv_mem [MAX_ENTRIES];
	logic [9:0]         ck_mem [MAX_ENTRIES];
	logic signed [31:0] cv_mem [MAX_ENTRIES];
	logic signed [31:0] sc_mem [ssdp_pkg::KEY_SPACE];

	logic [CW-1:0] row_cnt_q, col_cnt_q;
	logic          ovf_q;

	// Walk state: indices for next read, registered read data.
	logic [CW-1:0] ri_q, ci_q;
	logic [9:0]         rk_q, ck_q;
	logic signed [31:0] rv_q, cv_q, scd_q;
	// Phases: 0 read, 1 compare, 2 mult1, 3 mult2, 4 accumulate.
	localparam logic [2:0] PH_READ = 3'd0, PH_CMP = 3'd1, PH_M1 = 3'd2,
		PH_M2 = 3'd3, PH_ACC = 3'd4;
	logic [2:0] ph_q;
	logic       busy_q, done_q;
	logic       run_q, rsum_on_q, csum_on_q; // inside a match, summing
	logic [9:0] mk_q;
	logic signed [31:0] rs_q, cs_q, sc_q;
	logic signed [63:0] p_q, acc_q, term_q;
	logic signed [63:0] hi_q;
	logic signed [64:0] lo_q;
	logic       sat_q;

	wire r_ok = ri_q < row_cnt_q;
	wire c_ok = ci_q < col_cnt_q;

	// Loads and the registered memory reads.
	always_ff @(posedge clk) begin
		if (load_en && cmd == ssdp_pkg::CMD_ROW && row_cnt_q < CW'(MAX_ENTRIES)) begin
			rk_mem[row_cnt_q[IW-1:0]] <= key;
			rv_mem[row_cnt_q[IW-1:0]] <= value;
		end
		if (load_en && cmd == ssdp_pkg::CMD_COL && col_cnt_q < CW'(MAX_ENTRIES)) begin
			ck_mem[col_cnt_q[IW-1:0]] <= key;
			cv_mem[col_cnt_q[IW-1:0]] <= value;
		end
		if (load_en && cmd == ssdp_pkg::CMD_SCALE && 32'(key) < ssdp_pkg::KEY_SPACE) begin
			sc_mem[key[SW-1:0]] <= value;
		end
		rk_q <= rk_mem[ri_q[IW-1:0]];
		rv_q <= rv_mem[ri_q[IW-1:0]];
		ck_q <= ck_mem[ci_q[IW-1:0]];
		cv_q <= cv_mem[ci_q[IW-1:0]];
		scd_q <= sc_mem[mk_q[SW-1:0]];
	end

	// Saturating 32-bit add helper.
	function automatic logic signed [32:0] sat32(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'sd2147483647) return {1'b1, 32'sh7fff_ffff};
		if (s < -33'sd2147483648) return {1'b1, 32'sh8000_0000};
		return {1'b0, s[31:0]};
	endfunction

	logic signed [32:0] rsum_n, csum_n;
	logic signed [64:0] acc_n;
	logic        scl_ok;
	assign rsum_n = sat32(rs_q, rv_q);
	assign csum_n = sat32(cs_q, cv_q);
	assign acc_n  = 65'(acc_q) + 65'(term_q);
	assign scl_ok = 32'(mk_q) < ssdp_pkg::KEY_SPACE;

	// Merge walk. One list read per step; a match first sums row run, then column run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q <= '0; col_cnt_q <= '0; ovf_q <= 1'b0;
			busy_q <= 1'b0; done_q <= 1'b0; ph_q <= PH_READ;
			ri_q <= '0; ci_q <= '0; run_q <= 1'b0;
			rsum_on_q <= 1'b0; csum_on_q <= 1'b0; sat_q <= 1'b0; acc_q <= '0;
		end else begin
			if (load_en && cmd == ssdp_pkg::CMD_ROW) begin
				if (row_cnt_q < CW'(MAX_ENTRIES)) row_cnt_q <= row_cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (load_en && cmd == ssdp_pkg::CMD_COL) begin
				if (col_cnt_q < CW'(MAX_ENTRIES)) col_cnt_q <= col_cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (ctl.start) begin
				// An empty list finishes at once with a zero result.
				busy_q <= (row_cnt_q != '0) && (col_cnt_q != '0);
				done_q <= (row_cnt_q == '0) || (col_cnt_q == '0);
				ph_q <= PH_READ;
				ri_q <= '0; ci_q <= '0; acc_q <= '0; sat_q <= 1'b0;
				rsum_on_q <= 1'b0; csum_on_q <= 1'b0; run_q <= 1'b0;
			end else if (ctl.finish) begin
				done_q <= 1'b0; row_cnt_q <= '0; col_cnt_q <= '0; ovf_q <= 1'b0;
			end else if (busy_q && ctl.step) begin
				case (ph_q)
					PH_READ: ph_q <= PH_READ + 3'd1;
					PH_CMP: begin
						// The end of a column run moves on to the multiply.
						if (csum_on_q && !(c_ok && ck_q == mk_q)) ph_q <= PH_M1;
						else ph_q <= PH_READ;
						if (rsum_on_q) begin
							// Row run: add while key matches.
							if (r_ok && rk_q == mk_q) begin
								rs_q <= rsum_n[31:0];
								if (rsum_n[32]) sat_q <= 1'b1;
								ri_q <= ri_q + 1'b1;
							end else begin
								rsum_on_q <= 1'b0; csum_on_q <= 1'b1;
							end
						end else if (csum_on_q) begin
							if (c_ok && ck_q == mk_q) begin
								cs_q <= csum_n[31:0];
								if (csum_n[32]) sat_q <= 1'b1;
								ci_q <= ci_q + 1'b1;
							end else begin
								csum_on_q <= 1'b0;
							end
						end else if (!r_ok || !c_ok) begin
							busy_q <= 1'b0; done_q <= 1'b1;
						end else if (rk_q < ck_q) begin
							ri_q <= ri_q + 1'b1;
						end else if (ck_q < rk_q) begin
							ci_q <= ci_q + 1'b1;
						end else begin
							mk_q <= rk_q; rs_q <= '0; cs_q <= '0; rsum_on_q <= 1'b1;
						end
					end
					PH_M1: begin
						p_q <= 64'(rs_q) * 64'(cs_q);
						sc_q <= !scale_enable ? ssdp_pkg::ONE_Q16 : (scl_ok ? scd_q : '0);
						ph_q <= PH_M2;
					end
					PH_M2: begin
						// The 64-by-32 product is split into two 32-bit multiplies.
						hi_q <= $signed(p_q[63:32]) * sc_q;
						lo_q <= $signed({1'b0, p_q[31:0]}) * sc_q;
						ph_q <= PH_ACC;
						run_q <= 1'b1;
					end
					PH_ACC: begin
						if (run_q) begin
							// Floor of the full product shifted down by 32 bits.
							term_q <= hi_q + {{31{lo_q[64]}}, lo_q[64:32]};
							run_q <= 1'b0;
						end else begin
							if (acc_n[64] != acc_n[63]) begin
								sat_q <= 1'b1;
								acc_q <= acc_n[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
							end else acc_q <= acc_n[63:0];
							ph_q <= PH_READ;
						end
					end
					default: ph_q <= PH_READ;
				endcase
			end
		end
	end

	assign sts.done   = done_q;
	assign dot_result = acc_q;
	assign saturated  = sat_q;
	assign list_full  = ovf_q;

	// A finished walk is never still busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while busy");
	// Counts never exceed the list depth.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		row_cnt_q <= CW'(MAX_ENTRIES) && col_cnt_q <= CW'(MAX_ENTRIES))
		else $error("count overflow");
	// Only one summing run is open at once.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		!(rsum_on_q && csum_on_q)) else $error("two runs open");

endmodule

/* sv/ssdp_ctrl.sv */
// ----------------------------------------------------------------------------
// Sparse scaled dot product controller
// Sequences loads, compute walk and result delivery.
// ----------------------------------------------------------------------------
module ssdp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         cmd,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic               load_en,
	output ssdp_pkg::ctl_cmd_t ctl,
	input  ssdp_pkg::ctl_sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_OUT = 2'd2;
	logic [1:0] state_q;

	wire acc_in = s_tvalid && s_tready;

	// Only accept while idle; compute occupies the block until taken.
	assign s_tready = state_q == ST_IDLE;
	assign load_en  = acc_in && cmd != ssdp_pkg::CMD_COMPUTE;
	assign m_tvalid = state_q == ST_OUT;
	assign ctl.start  = acc_in && cmd == ssdp_pkg::CMD_COMPUTE;
	assign ctl.step   = state_q == ST_RUN;
	assign ctl.finish = m_tvalid && m_tready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (ctl.start) state_q <= ST_RUN;
				ST_RUN:  if (sts.done) state_q <= ST_OUT;
				ST_OUT:  if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result is held until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	// No input accepted while a result waits.
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input during output");
	// The state always holds one of the defined codes.
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE || state_q == ST_RUN || state_q == ST_OUT)
		else $error("illegal state");

endmodule

/* sv/sparse_scaled_dot_product.sv */
// ----------------------------------------------------------------------------
// Sparse scaled dot product
// Compute: a merge walk over both lists, with a multiply and accumulate per matched key.
// Throughput: one load word per cycle while idle; one compute at a time.
// Reset: asynchronous, clears counts, flags and control; memories are not cleared.
// ----------------------------------------------------------------------------
module sparse_scaled_dot_product #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cmd[1:0], key[11:2], value[43:12], zero pad
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [71:0] m_tdata,   // dot_result[63:0], saturated[64], list_full[65], pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic scale_en_q, load_en, sat, full;
	logic signed [63:0] dot;
	ssdp_pkg::ctl_cmd_t ctl;
	ssdp_pkg::ctl_sts_t sts;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_en_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == ssdp_pkg::REG_SCALE_EN)
			scale_en_q <= pwdata[0];
	end
	assign prdata = (paddr == ssdp_pkg::REG_SCALE_EN) ? {31'd0, scale_en_q} : 32'd0;

	ssdp_ctrl u_ctrl (.clk, .arst_n, .s_tvalid, .s_tready, .cmd(s_tdata[1:0]),
		.m_tvalid, .m_tready, .load_en, .ctl, .sts);

	ssdp_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk, .arst_n, .load_en, .cmd(s_tdata[1:0]), .key(s_tdata[11:2]),
		.value(s_tdata[43:12]), .scale_enable(scale_en_q), .ctl, .sts,
		.dot_result(dot), .saturated(sat), .list_full(full));

	assign m_tdata = {6'd0, full, sat, dot};

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Sparse scaled dot product testbench
// Loads sparse rows, columns and scale entries, issues compute commands and
// checks every result word against an in-bench merge-walk predictor, with
// random sender bursts, receiver stalls and scale_enable changes between phases.
// ----------------------------------------------------------------------------
module tb;

	localparam int          DEPTH      = 256;
	localparam int          KEYS       = ssdp_pkg::KEY_SPACE;
	localparam int          TARGET     = 1450;
	localparam int          LIMIT      = 1500000;
	localparam int          SETTLE     = 40;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  key;
		logic [31:0] value;
	} load_word_t;

	typedef struct packed {
		logic signed [63:0] dot;
		logic               sat;
		logic               full;
	} dot_word_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tready = 0;
	logic        m_tvalid;
	logic [71:0] m_tdata;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sparse_scaled_dot_product DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor copy of the block state.
	logic [9:0]         row_key [DEPTH];
	logic signed [31:0] row_val [DEPTH];
	logic [9:0]         col_key [DEPTH];
	logic signed [31:0] col_val [DEPTH];
	logic signed [31:0] scale_tab [KEYS];
	bit                 scale_known [KEYS];
	int                 row_cnt = 0;
	int                 col_cnt = 0;
	bit                 dropped = 0;
	bit                 scale_on = 0;

	load_word_t pending_loads[$];
	dot_word_t  expected_dots[$];
	int         loads_made = 0;
	int         errors = 0;
	int         cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic signed [31:0] add_sat32(logic signed [31:0] a,
			logic signed [31:0] b, ref bit sat);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647) begin
			sat = 1;
			return 32'sh7fff_ffff;
		end
		if (s < -64'sd2147483648) begin
			sat = 1;
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

	function automatic logic signed [63:0] add_sat64(logic signed [63:0] a,
			logic signed [63:0] b, ref bit sat);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			sat = 1;
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s[63:0];
	endfunction

	// Exact product of the two sums and the scale, floored back to Q.16.
	function automatic logic signed [63:0] scaled_term(logic signed [31:0] rs,
			logic signed [31:0] cs, logic signed [31:0] sc);
		longint             p;
		logic signed [95:0] pw, sw, t;
		p = longint'(rs) * longint'(cs);
		pw = p;
		sw = sc;
		t = pw * sw;
		return t[95:32];
	endfunction

	// Merge walk over both lists, summing runs of equal keys on each side.
	function automatic dot_word_t merge_dot();
		dot_word_t          r;
		int                 ri, ci;
		bit                 going, sat;
		logic [9:0]         k;
		logic signed [31:0] rs, cs, sc;
		logic signed [63:0] acc;
		ri = 0;
		ci = 0;
		acc = 0;
		sat = 0;
		going = (row_cnt != 0) && (col_cnt != 0);
		while (going && ri < row_cnt && ci < col_cnt) begin
			while (going && row_key[ri] < col_key[ci]) begin
				ri++;
				if (ri >= row_cnt) going = 0;
			end
			while (going && col_key[ci] < row_key[ri]) begin
				ci++;
				if (ci >= col_cnt) going = 0;
			end
			if (going) begin
				k = row_key[ri];
				if (k == col_key[ci]) begin
					rs = 0;
					cs = 0;
					do begin
						rs = add_sat32(rs, row_val[ri], sat);
						ri++;
					end while (ri < row_cnt && row_key[ri] == k);
					do begin
						cs = add_sat32(cs, col_val[ci], sat);
						ci++;
					end while (ci < col_cnt && col_key[ci] == k);
					sc = scale_on ? scale_tab[k] : ssdp_pkg::ONE_Q16;
					acc = add_sat64(acc, scaled_term(rs, cs, sc), sat);
				end
			end
		end
		r.dot = acc;
		r.sat = sat;
		r.full = dropped;
		return r;
	endfunction

	// Queue one load word and update the predicted state.
	function automatic void queue_load(logic [1:0] cmd, logic [9:0] key,
			logic [31:0] value);
		load_word_t w;
		w.cmd = cmd;
		w.key = key;
		w.value = value;
		pending_loads = {pending_loads, w};
		loads_made++;
		case (cmd)
			ssdp_pkg::CMD_ROW: begin
				if (row_cnt < DEPTH) begin
					row_key[row_cnt] = key;
					row_val[row_cnt] = value;
					row_cnt++;
				end else dropped = 1;
			end
			ssdp_pkg::CMD_COL: begin
				if (col_cnt < DEPTH) begin
					col_key[col_cnt] = key;
					col_val[col_cnt] = value;
					col_cnt++;
				end else dropped = 1;
			end
			ssdp_pkg::CMD_SCALE: begin
				scale_tab[key] = value;
				scale_known[key] = 1;
			end
			default: begin
				expected_dots = {expected_dots, merge_dot()};
				row_cnt = 0;
				col_cnt = 0;
				dropped = 0;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
		endcase
	endfunction

	// Compute, first filling in any scale slot the walk could read.
	function automatic void queue_compute();
		if (scale_on)
			for (int i = 0; i < row_cnt; i++)
				if (!scale_known[row_key[i]])
					queue_load(ssdp_pkg::CMD_SCALE, row_key[i], pick_value());
		queue_load(ssdp_pkg::CMD_COMPUTE, 10'($urandom), $urandom);
	endfunction

	// One random data set: interleaved row and column appends with random scale loads, then compute.
	function automatic void random_set();
		int         nr, nc, pick;
		bit         messy;
		logic [9:0] kr, kc, kbase;
		pick = $urandom_range(0, 39);
		nr = (pick == 0) ? DEPTH + 1 : (pick < 4) ? $urandom_range(0, 40)
			: $urandom_range(0, 8);
		pick = $urandom_range(0, 39);
		nc = (pick == 0) ? DEPTH + 1 : (pick < 4) ? $urandom_range(0, 40)
			: $urandom_range(0, 8);
		messy = ($urandom_range(0, 7) == 0);
		kbase = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1000)) : 10'd0;
		kr = kbase;
		kc = kbase;
		while (nr > 0 || nc > 0) begin
			if ($urandom_range(0, 15) == 0)
				queue_load(ssdp_pkg::CMD_SCALE, 10'($urandom), pick_value());
			if (nr > 0 && (nc == 0 || $urandom_range(0, 1))) begin
				queue_load(ssdp_pkg::CMD_ROW, messy ? 10'($urandom) : kr, pick_value());
				if (kr < 10'd1021) kr += 10'($urandom_range(0, 2));
				nr--;
			end else begin
				queue_load(ssdp_pkg::CMD_COL, messy ? 10'($urandom) : kc, pick_value());
				if (kc < 10'd1021) kc += 10'($urandom_range(0, 2));
				nc--;
			end
		end
		queue_compute();
	endfunction

	task automatic write_scale_enable(bit en);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= ssdp_pkg::REG_SCALE_EN;
		pwdata <= {31'd0, en};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		scale_on = en;
	endtask

	task automatic wait_idle();
		while (pending_loads.size() != 0 || s_tvalid || expected_dots.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	// Stimulus: directed checks, then random phases with scale_enable changes.
	initial begin
		int phase;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		write_scale_enable(0);
		queue_compute();
		queue_load(ssdp_pkg::CMD_ROW, 10'd0, 32'h7fff_ffff);
		queue_load(ssdp_pkg::CMD_ROW, 10'd0, 32'h7fff_ffff);
		queue_load(ssdp_pkg::CMD_ROW, 10'd1023, 32'h8000_0000);
		queue_load(ssdp_pkg::CMD_COL, 10'd0, 32'h8000_0000);
		queue_load(ssdp_pkg::CMD_COL, 10'd1023, 32'h8000_0000);
		queue_compute();
		queue_load(ssdp_pkg::CMD_ROW, 10'd5, 32'h0001_0000);
		queue_compute();
		queue_load(ssdp_pkg::CMD_ROW, 10'd9, 32'h0003_0000);
		queue_load(ssdp_pkg::CMD_ROW, 10'd2, 32'hfffe_8000);
		queue_load(ssdp_pkg::CMD_COL, 10'd2, 32'h0002_0000);
		queue_load(ssdp_pkg::CMD_COL, 10'd9, 32'h0001_0000);
		queue_compute();
		wait_idle();
		write_scale_enable(1);
		for (int k = 1; k <= 4; k++) begin
			queue_load(ssdp_pkg::CMD_SCALE, 10'(k), 32'h8000_0000);
			queue_load(ssdp_pkg::CMD_ROW, 10'(k), 32'h7fff_ffff);
			queue_load(ssdp_pkg::CMD_COL, 10'(k), 32'h7fff_ffff);
		end
		queue_load(ssdp_pkg::CMD_SCALE, 10'd1023, 32'h7fff_ffff);
		queue_load(ssdp_pkg::CMD_ROW, 10'd1023, 32'h0001_0000);
		queue_load(ssdp_pkg::CMD_COL, 10'd1023, 32'hffff_0000);
		queue_compute();
		phase = 0;
		while (loads_made < TARGET) begin
			for (int s = 0; s < 12 && loads_made < TARGET; s++) random_set();
			wait_idle();
			phase++;
			write_scale_enable(phase % 3 != 0);
		end
		wait_idle();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Driver: bursts of words with random gaps between them.
	bit taken = 0;
	int burst = 4;
	int gap = 0;
	always @(posedge clk) taken <= s_tvalid && s_tready;

	always @(negedge clk) begin
		if (taken) void'(pending_loads.pop_front());
		if (s_tvalid && !taken) begin
			// Hold the word until it is accepted.
		end else if (gap > 0) begin
			s_tvalid <= 0;
			gap--;
		end else if (pending_loads.size() != 0) begin
			s_tvalid <= 1;
			s_tdata <= {4'd0, pending_loads[0].value, pending_loads[0].key,
				pending_loads[0].cmd};
			burst--;
			if (burst <= 0) begin
				burst = $urandom_range(1, 40);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else s_tvalid <= 0;
	end

	// Receiver: stall pattern is picked anew at random, periodically.
	int stall_mode = 0;
	always @(negedge clk) begin
		if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= (cycles % 5 == 0);
		endcase
	end

	// Monitor: compare each result word with the oldest predicted one.
	always @(posedge clk) begin
		dot_word_t want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dots.size() == 0) begin
				report("unexpected word", m_tdata[63:0], 64'd0);
			end else begin
				want = expected_dots.pop_front();
				if (m_tdata[63:0] !== want.dot) report("dot_result", m_tdata[63:0], want.dot);
				if (m_tdata[64] !== want.sat)
					report("saturated", 64'(m_tdata[64]), 64'(want.sat));
				if (m_tdata[65] !== want.full)
					report("list_full", 64'(m_tdata[65]), 64'(want.full));
			end
		end
		if (cycles > LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

endmodule

/* files.f */
sv/ssdp_pkg.sv
sv/ssdp_datapath.sv
sv/ssdp_ctrl.sv
sv/sparse_scaled_dot_product.sv
tb/sv/tb.sv
